@@ rtl/core/udpck_pkg.sv @@
package udpck_pkg;

  localparam int unsigned PosW  = 17;
  localparam int unsigned WordW = 16;

  localparam logic [PosW-1:0] PosMax = '1;

  // frame offsets
  localparam logic [PosW-1:0] IpHdrStart = 17'd14;
  localparam logic [PosW-1:0] IpHdrEnd   = 17'd34;
  localparam logic [PosW-1:0] AddrStart  = 17'd26;
  localparam logic [PosW-1:0] IpCsumOff  = 17'd24;
  localparam logic [PosW-1:0] UdpCsumOff = 17'd40;

  // position of the last byte: short below MinLastPos, long at or above MaxLastPos
  localparam logic [PosW-1:0] MinLastPos = 17'd41;
  localparam logic [PosW-1:0] MaxLastPos = 17'd65549;

  // UDP length = last position + 1 - 34
  localparam logic [WordW-1:0] UdpLenAdj = 16'd33;
  localparam logic [WordW-1:0] ProtoUdp  = 16'd17;
  localparam logic [WordW-1:0] CsumZeroSub = 16'hffff;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusShort = 2'd1,
    StatusLong  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] ip_csum;
    logic [WordW-1:0] udp_csum;
    status_e          status;
  } result_t;

  // ones' complement add with end-around carry
  function automatic logic [WordW-1:0] ones_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

@@ rtl/core/udpck_in_stage.sv @@
module udpck_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  udpck_pkg::item_t item_i,
  output logic             valid_o,
  input  logic             take_i,
  output udpck_pkg::item_t item_o
);
  import udpck_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

`ifndef SYNTHESIS
  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("take without a held item");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && item_q == $past(item_q))
    else $error("held item lost while stalled");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_q)
    else $error("accepted transaction not held");
`endif

endmodule

@@ rtl/core/udpck_accum.sv @@
module udpck_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  udpck_pkg::item_t    item_i,
  output udpck_pkg::result_t  result_o
);
  import udpck_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [WordW-1:0] ip_sum_q, ip_sum_d;
  logic [WordW-1:0] udp_sum_q, udp_sum_d;
  logic [7:0]       held_q, held_d;

  logic [PosW-1:0]  word_start;
  logic [WordW-1:0] word;
  logic [WordW-1:0] ip_upd, udp_upd;
  logic [WordW-1:0] us_pad, us_proto, us_len, udp_inv;
  status_e          status;

  assign word_start = pos_q - 17'd1;

  always_comb begin
    word = {held_q, item_i.frame_byte};
    if (word_start == IpCsumOff || word_start == UdpCsumOff) begin
      word = '0;
    end
  end

  // sums after this byte
  always_comb begin
    ip_upd  = ip_sum_q;
    udp_upd = udp_sum_q;
    held_d  = held_q;
    if (!pos_q[0]) begin
      held_d = item_i.frame_byte;
    end else if (pos_q != PosMax) begin
      if (word_start >= IpHdrStart && word_start < IpHdrEnd) begin
        ip_upd = ones_add(ip_sum_q, word);
      end
      if (word_start >= AddrStart) begin
        udp_upd = ones_add(udp_sum_q, word);
      end
    end
  end

  // final fold: odd trailing byte, then pseudo-header protocol and length
  always_comb begin
    us_pad = udp_upd;
    if (!pos_q[0] && pos_q != UdpCsumOff) begin
      us_pad = ones_add(udp_upd, {item_i.frame_byte, 8'h00});
    end
    us_proto = ones_add(us_pad, ProtoUdp);
    us_len   = ones_add(us_proto, pos_q[WordW-1:0] - UdpLenAdj);
    udp_inv  = ~us_len;
  end

  always_comb begin
    if (pos_q < MinLastPos) begin
      status = StatusShort;
    end else if (pos_q >= MaxLastPos) begin
      status = StatusLong;
    end else begin
      status = StatusOk;
    end
  end

  always_comb begin
    result_o.status   = status;
    result_o.ip_csum  = '0;
    result_o.udp_csum = '0;
    if (status == StatusOk) begin
      result_o.ip_csum  = ~ip_upd;
      result_o.udp_csum = (udp_inv == '0) ? CsumZeroSub : udp_inv;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    ip_sum_d  = ip_sum_q;
    udp_sum_d = udp_sum_q;
    if (take_i) begin
      if (item_i.is_last) begin
        pos_d     = '0;
        ip_sum_d  = '0;
        udp_sum_d = '0;
      end else begin
        ip_sum_d  = ip_upd;
        udp_sum_d = udp_upd;
        if (pos_q != PosMax) begin
          pos_d = pos_q + 17'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ip_sum_q  <= '0;
      udp_sum_q <= '0;
      held_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      ip_sum_q  <= ip_sum_d;
      udp_sum_q <= udp_sum_d;
      if (take_i) begin
        held_q <= item_i.is_last ? 8'h00 : held_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.is_last |=> pos_q == '0 && ip_sum_q == '0 && udp_sum_q == '0)
    else $error("state not cleared after end of frame");

  a_pos_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !item_i.is_last && pos_q != PosMax |=> pos_q == $past(pos_q) + 17'd1)
    else $error("byte position did not advance");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> pos_q == $past(pos_q))
    else $error("byte position moved without a byte");
`endif

endmodule

@@ rtl/core/udpck_out_stage.sv @@
module udpck_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  udpck_pkg::result_t result_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output udpck_pkg::result_t result_o
);
  import udpck_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten while full");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not presented");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_i && !load_i |=> !valid_q)
    else $error("result repeated after transaction");
`endif

endmodule

@@ rtl/core/udp_ipv4_checksum_engine_top.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | frame_byte_i[7:0], is_last_i
// out     | output    | out_valid_o / out_ready_i  | ip_header_checksum_o[15:0],
//         |           |                            | udp_datagram_checksum_o[15:0],
//         |           |                            | frame_status_o[1:0]
//
// One byte per cycle sustained, except where a last byte waits (below). A byte is
// held in the input register, then folded into the running sums; the last byte
// of a frame loads the result register, from which the result is presented.
// Reset (rst_ni low, asynchronous) clears the byte count, both sums and valids.
// Only a last byte waits on a full result register; other bytes flow freely,
// so the out side stalls the in side only at frame ends.
module udp_ipv4_checksum_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] ip_header_checksum_o,
  output logic [15:0] udp_datagram_checksum_o,
  output logic [1:0]  frame_status_o
);
  import udpck_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid;
  logic    take;
  logic    out_free;
  result_t next_result, out_result;

  assign in_item.frame_byte = frame_byte_i;
  assign in_item.is_last    = is_last_i;

  // a byte leaves the input register unless it ends a frame while a result waits
  assign take = held_valid && (!held_item.is_last || out_free);

  udpck_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (take),
    .item_o  (held_item)
  );

  udpck_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (held_item),
    .result_o (next_result)
  );

  udpck_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take && held_item.is_last),
    .result_i (next_result),
    .free_o   (out_free),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign ip_header_checksum_o    = out_result.ip_csum;
  assign udp_datagram_checksum_o = out_result.udp_csum;
  assign frame_status_o          = out_result.status;

`ifndef SYNTHESIS
  a_bad_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o != StatusOk
      |-> ip_header_checksum_o == '0 && udp_datagram_checksum_o == '0)
    else $error("flagged frame with non-zero checksum");

  a_udp_never_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == StatusOk |-> udp_datagram_checksum_o != '0)
    else $error("zero UDP checksum sent");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o == StatusOk || frame_status_o == StatusShort
      || frame_status_o == StatusLong)
    else $error("undefined frame status");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import udpck_pkg::*;

  // Frame layout and limits, as the predictor sees them
  localparam int unsigned IpFrom     = 14;     // first byte of the IPv4 header
  localparam int unsigned IpTo       = 34;     // one past the IPv4 header
  localparam int unsigned AddrFrom   = 26;     // source address, start of pseudo-header
  localparam int unsigned UdpFrom    = 34;     // first byte of the UDP header
  localparam int unsigned IpCkAt     = 24;     // IPv4 checksum field
  localparam int unsigned UdpCkAt    = 40;     // UDP checksum field
  localparam int unsigned ShortBelow = 42;
  localparam int unsigned LongAbove  = 65549;
  localparam logic [15:0] ProtoNum   = 16'd17;
  localparam logic [16:0] PosTop     = 17'h1ffff;

  localparam int unsigned RxHoldCycles = 200;  // long back-pressure stretch
  localparam int unsigned StallLimit   = 2000; // cycles with no transaction at all
  localparam int unsigned DrainCycles  = 16;
  localparam int          NoPoke       = -1;

  // One frame of stimulus; want is only used when typed is set
  typedef struct {
    int          len;
    logic [7:0]  fill;
    bit          rnd;
    int          poke_at;
    logic [15:0] poke_word;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  frame_byte_i = 8'h00;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] ip_header_checksum_o;
  logic [15:0] udp_datagram_checksum_o;
  logic [1:0]  frame_status_o;

  udp_ipv4_checksum_engine_top u_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state: mirrors the block's byte counter, both running sums and
  // the high byte waiting for its partner
  logic [16:0] ck_pos;
  logic [15:0] ck_ip_sum;
  logic [15:0] ck_udp_sum;
  logic [7:0]  ck_hi_byte;

  result_t csum_expected_q[$];
  int      mismatch_cnt = 0;
  bit      idle_en = 1'b1;     // random idling on both sides
  bit      rx_hold_req = 1'b0; // raised by the sender, cleared by the receiver

  // Directed frames. Rows with typed set carry a result that is obvious by
  // inspection; the rest go through the predictor.
  frame_row_t dir_rows [11] = '{
    // short frames: status only, both sums zero
    '{1,      8'h00, 1'b0, NoPoke, 16'h0000, 1'b1, '{16'h0000, 16'h0000, StatusShort}},
    '{2,      8'hff, 1'b0, NoPoke, 16'h0000, 1'b1, '{16'h0000, 16'h0000, StatusShort}},
    '{41,     8'hff, 1'b0, NoPoke, 16'h0000, 1'b1, '{16'h0000, 16'h0000, StatusShort}},
    // minimum frame of zeros: UDP sum is just proto + length 8
    '{42,     8'h00, 1'b0, NoPoke, 16'h0000, 1'b1, '{16'hffff, 16'hffe6, StatusOk}},
    // UDP word chosen so the inverted sum is zero, sent as all ones
    '{42,     8'h00, 1'b0, 34,     16'hffe6, 1'b1, '{16'hffff, 16'hffff, StatusOk}},
    // junk in either checksum field must be ignored
    '{42,     8'h00, 1'b0, 24,     16'habcd, 1'b1, '{16'hffff, 16'hffe6, StatusOk}},
    '{42,     8'h00, 1'b0, 40,     16'h1234, 1'b1, '{16'hffff, 16'hffe6, StatusOk}},
    // odd length, trailing byte padded low; then random bytes via the predictor
    '{43,     8'hff, 1'b0, NoPoke, 16'h0000, 1'b0, '{16'h0000, 16'h0000, StatusOk}},
    '{42,     8'h00, 1'b1, NoPoke, 16'h0000, 1'b0, '{16'h0000, 16'h0000, StatusOk}},
    // state must be clear again between frames
    '{1,      8'h00, 1'b0, NoPoke, 16'h0000, 1'b1, '{16'h0000, 16'h0000, StatusShort}},
    '{42,     8'h00, 1'b0, NoPoke, 16'h0000, 1'b1, '{16'hffff, 16'hffe6, StatusOk}}
  };

  // ones' complement add, end-around carry folded straight back in
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // Folds one accepted byte into the predicted sums; on the last byte it
  // yields the expected result and clears for the next frame
  task automatic step_checksums(input logic [7:0] b, input logic last,
                                output bit has_res, output result_t res);
    logic [16:0] p;
    logic [16:0] start;
    logic [15:0] w;
    logic [15:0] us;
    int unsigned flen;
    p = ck_pos;
    has_res = 1'b0;
    res = '0;
    if (!p[0]) begin
      ck_hi_byte = b;
    end else if (p != PosTop) begin
      start = p - 17'd1;
      w = {ck_hi_byte, b};
      if (start == IpCkAt || start == UdpCkAt) w = '0;
      if (start >= IpFrom && start < IpTo) ck_ip_sum = oc_add(ck_ip_sum, w);
      if (start >= AddrFrom) ck_udp_sum = oc_add(ck_udp_sum, w);
    end
    if (p != PosTop) ck_pos = p + 17'd1;
    if (last) begin
      has_res = 1'b1;
      flen = {15'd0, p};
      flen = flen + 1;
      if (flen < ShortBelow) begin
        res.status = StatusShort;
      end else if (flen > LongAbove) begin
        res.status = StatusLong;
      end else begin
        res.status = StatusOk;
        us = ck_udp_sum;
        if (!p[0] && p != UdpCkAt) us = oc_add(us, {b, 8'h00});
        us = oc_add(us, ProtoNum);
        us = oc_add(us, 16'(flen - UdpFrom));
        res.udp_csum = ~us;
        if (res.udp_csum == 16'h0000) res.udp_csum = 16'hffff;
        res.ip_csum = ~ck_ip_sum;
      end
      ck_pos = '0;
      ck_ip_sum = '0;
      ck_udp_sum = '0;
      ck_hi_byte = '0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Offers one byte, holds it until the transaction completes, then updates
  // the prediction. A typed row overrides the predicted result.
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input bit typed, input result_t want);
    bit      has_res;
    result_t res;
    if (idle_en && $urandom_range(0, 15) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    is_last_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    step_checksums(b, last, has_res, res);
    if (has_res) csum_expected_q.push_back(typed ? want : res);
  endtask

  // Biased towards all-zero and all-one bytes to stress the carry folding
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input frame_row_t row);
    logic [7:0] b;
    for (int i = 0; i < row.len; i++) begin
      if (row.poke_at != NoPoke && i == row.poke_at) b = row.poke_word[15:8];
      else if (row.poke_at != NoPoke && i == row.poke_at + 1) b = row.poke_word[7:0];
      else if (row.rnd) b = pick_byte();
      else b = row.fill;
      push_byte(b, i == row.len - 1, row.typed, row.want);
    end
  endtask

  // Mostly well-formed frame lengths, with some short runts and a few
  // longer datagrams
  function automatic frame_row_t pick_frame();
    frame_row_t r;
    int sel;
    r = '{0, 8'h00, 1'b1, NoPoke, 16'h0000, 1'b0, '0};
    sel = $urandom_range(0, 99);
    if (sel < 60)      r.len = $urandom_range(42, 48);
    else if (sel < 90) r.len = $urandom_range(1, 41);
    else               r.len = $urandom_range(49, 72);
    return r;
  endfunction

  // The sender drops valid and stands back until every result is out
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (csum_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure bursts, plus one long hold on request
  initial begin : rx_side
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker: every result transaction against the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (csum_expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result ip=%h udp=%h status=%0d",
                                ip_header_checksum_o, udp_datagram_checksum_o,
                                frame_status_o));
      end else begin
        want = csum_expected_q.pop_front();
        if (ip_header_checksum_o !== want.ip_csum ||
            udp_datagram_checksum_o !== want.udp_csum ||
            frame_status_o !== want.status) begin
          flag_mismatch($sformatf("ip exp %h got %h, udp exp %h got %h, status exp %0d got %0d",
                                  want.ip_csum, ip_header_checksum_o,
                                  want.udp_csum, udp_datagram_checksum_o,
                                  want.status, frame_status_o));
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel completes a transaction for
  // too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    frame_row_t runt;
    ck_pos = '0;
    ck_ip_sum = '0;
    ck_udp_sum = '0;
    ck_hi_byte = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_frame(dir_rows[k]);

    repeat (2) send_frame(pick_frame());

    // sender stands back until the block has fully drained
    wait_all_results();
    repeat (1) send_frame(pick_frame());

    // long receiver hold while runts keep arriving: the result register
    // fills and the input side has to stall on a last byte
    rx_hold_req = 1'b1;
    runt = '{0, 8'h00, 1'b1, NoPoke, 16'h0000, 1'b0, '0};
    repeat (10) begin
      runt.len = $urandom_range(1, 3);
      send_frame(runt);
    end
    repeat (1) send_frame(pick_frame());

    // final stretch at full rate on both sides
    idle_en = 1'b0;
    repeat (1) send_frame(pick_frame());
    in_valid_i <= 1'b0;

    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && csum_expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/udpck_pkg.sv
rtl/core/udpck_in_stage.sv
rtl/core/udpck_accum.sv
rtl/core/udpck_out_stage.sv
rtl/core/udp_ipv4_checksum_engine_top.sv
tb/testbench.sv
